FILE: rtl/core/sbn_pkg.sv
// Shared constants for the sphere boundary normal block.
// Register indexes and default widths; no dependencies.
`default_nettype none
package sbn_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int IDX_W          = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_INSIDE    = 3'd4,
    REG_MAX_DIST  = 3'd5,
    REG_BND_COUNT = 3'd6,
    REG_MK_RANGE  = 3'd7
  } reg_idx_t;

  localparam logic [31:0] MK_RANGE_RST = 32'hFFFF0000;
endpackage
`default_nettype wire

FILE: rtl/core/sbn_div.sv
// One lane of the pipelined restoring divider with signed saturation.
// One quotient bit per stage; uses no package items.
`default_nettype none
module sbn_div #(
  parameter int W  = 32,
  parameter int DW = 34
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [W+DW:0]       n,
  input  wire logic [DW-1:0]       d,
  input  wire logic                neg,
  input  wire logic                kill,
  output logic      [W-1:0]        q_out
);
  localparam int NW = W + 1 + DW;

  logic [DW-1:0] rem  [0:W];
  logic [W-1:0]  low  [0:W];
  logic [DW-1:0] dd   [0:W];
  logic [W-1:0]  qq   [0:W];
  logic          ng   [0:W];
  logic          ov   [0:W];
  logic          kl   [0:W];

  logic [NW-1:0] d_top;
  assign d_top = NW'({d, {W{1'b0}}});

  // load: overflow check, high part of the dividend becomes the first remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n[NW-2:W];
      low[0] <= n[W-1:0];
      dd[0]  <= d;
      qq[0]  <= '0;
      ng[0]  <= neg;
      ov[0]  <= (n >= d_top);
      kl[0]  <= kill;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [DW:0] rem_sh;
    logic        ge;
    assign rem_sh = {rem[i], low[i][W-1]};
    assign ge     = (rem_sh >= {1'b0, dd[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? DW'(rem_sh - {1'b0, dd[i]}) : DW'(rem_sh);
        low[i+1] <= {low[i][W-2:0], 1'b0};
        dd[i+1]  <= dd[i];
        qq[i+1]  <= {qq[i][W-2:0], ge};
        ng[i+1]  <= ng[i];
        ov[i+1]  <= ov[i];
        kl[i+1]  <= kl[i];
      end
    end
  end

  // saturate to the signed range and apply the sign
  localparam logic [W-1:0] MAXP  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CSIGN = {1'b1, {(W-1){1'b0}}};
  logic [W-1:0] mag;
  always_comb begin
    if (!ng[W]) begin
      mag = (ov[W] || qq[W] > MAXP) ? MAXP : qq[W];
    end else begin
      mag = (ov[W] || qq[W] > CSIGN) ? CSIGN : qq[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (kl[W]) begin
        q_out <= '0;
      end else begin
        q_out <= ng[W] ? W'(-mag) : mag;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sphere_boundary_normal.sv
// Top level of the sphere boundary normal block: selection, distance,
// square root pipeline and three divider lanes. Uses sbn_pkg and sbn_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_ready     | pos_x pos_y pos_z particle_id mk_type last_particle
//  out      | out_valid / out_ready   | normal_x normal_y normal_z written last_out
//  cfg      | cfg_we (no wait)        | cfg_index cfg_data
//
// One transaction per cycle enters while the pipeline advances; the square root
// and divider pipelines each resolve one bit per stage.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset clears the valid bits and the configuration registers.
`default_nettype none
module sphere_boundary_normal #(
  parameter int COORD_BITS = sbn_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_BITS-1:0]  pos_x,
  input  wire logic [COORD_BITS-1:0]  pos_y,
  input  wire logic [COORD_BITS-1:0]  pos_z,
  input  wire logic [31:0]            particle_id,
  input  wire logic [15:0]            mk_type,
  input  wire logic                   last_particle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COORD_BITS-1:0]       normal_x,
  output logic [COORD_BITS-1:0]       normal_y,
  output logic [COORD_BITS-1:0]       normal_z,
  output logic                        written,
  output logic                        last_out,
  input  wire logic                   cfg_we,
  input  wire logic [sbn_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [((COORD_BITS > 32) ? COORD_BITS : 32)-1:0] cfg_data
);
  localparam int W   = COORD_BITS;
  localparam int DW  = W + 2;          // root width
  localparam int SW  = 2 * DW;         // sum of squares width
  localparam int RW  = DW + 2;         // root remainder width
  localparam int NW  = W + 1 + DW;     // dividend width
  localparam int LAT = W + DW + 8;

  // configuration registers
  logic [W-1:0]  center_x, center_y, center_z;
  logic [W-2:0]  radius, max_dist;
  logic          inside_mode;
  logic [31:0]   boundary_count, mk_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      radius         <= '0;
      inside_mode    <= 1'b0;
      max_dist       <= '0;
      boundary_count <= '0;
      mk_range       <= sbn_pkg::MK_RANGE_RST;
    end else if (cfg_we) begin
      unique case (sbn_pkg::reg_idx_t'(cfg_index))
        sbn_pkg::REG_CENTER_X:  center_x       <= cfg_data[W-1:0];
        sbn_pkg::REG_CENTER_Y:  center_y       <= cfg_data[W-1:0];
        sbn_pkg::REG_CENTER_Z:  center_z       <= cfg_data[W-1:0];
        sbn_pkg::REG_RADIUS:    radius         <= cfg_data[W-2:0];
        sbn_pkg::REG_INSIDE:    inside_mode    <= cfg_data[0];
        sbn_pkg::REG_MAX_DIST:  max_dist       <= cfg_data[W-2:0];
        sbn_pkg::REG_BND_COUNT: boundary_count <= cfg_data[31:0];
        sbn_pkg::REG_MK_RANGE:  mk_range       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // valid, selection and last flag travel alongside the data
  logic vld [0:LAT-1];
  logic wr  [0:LAT-1];
  logic lst [0:LAT-1];

  logic sel_in;
  assign sel_in = (particle_id < boundary_count) && (mk_type >= mk_range[15:0])
                  && (mk_type <= mk_range[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr[0]  <= sel_in;
      lst[0] <= last_particle;
      for (int i = 1; i < LAT; i++) begin
        wr[i]  <= wr[i-1];
        lst[i] <= lst[i-1];
      end
    end
  end

  // stage 1: offsets from the centre
  logic [W:0] dx1, dy1, dz1;
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {pos_x[W-1], pos_x} - {center_x[W-1], center_x};
      dy1 <= {pos_y[W-1], pos_y} - {center_y[W-1], center_y};
      dz1 <= {pos_z[W-1], pos_z} - {center_z[W-1], center_z};
    end
  end

  // stage 2: squares of the magnitudes
  logic [W:0]     mx1, my1, mz1;
  logic [2*W+1:0] sqx2, sqy2, sqz2;
  logic [W:0]     dx2, dy2, dz2;
  assign mx1 = dx1[W] ? (W+1)'(-dx1) : dx1;
  assign my1 = dy1[W] ? (W+1)'(-dy1) : dy1;
  assign mz1 = dz1[W] ? (W+1)'(-dz1) : dz1;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= mx1 * mx1;
      sqy2 <= my1 * my1;
      sqz2 <= mz1 * mz1;
      dx2  <= dx1;
      dy2  <= dy1;
      dz2  <= dz1;
    end
  end

  // stage 3: sum of squares, squared radius and limit bounds
  logic [SW-1:0]  s3;
  logic [2*W-3:0] r2_3, lo2_3;
  logic [2*W-1:0] hi2_3;
  logic [W:0]     dx3, dy3, dz3;
  logic [W-2:0]   r_lo;
  logic [W-1:0]   r_hi;
  assign r_lo = radius - max_dist;
  assign r_hi = {1'b0, radius} + {1'b0, max_dist};
  always_ff @(posedge clk) begin
    if (en) begin
      s3    <= SW'(sqx2) + SW'(sqy2) + SW'(sqz2);
      r2_3  <= radius * radius;
      lo2_3 <= r_lo * r_lo;
      hi2_3 <= r_hi * r_hi;
      dx3   <= dx2;
      dy3   <= dy2;
      dz3   <= dz2;
    end
  end

  // stage 4: side and distance limit decisions, feed the root pipeline
  logic act3;
  always_comb begin
    act3 = 1'b0;
    if (inside_mode && s3 < SW'(r2_3)) begin
      act3 = (max_dist == '0) || (radius <= max_dist) || (s3 >= SW'(lo2_3));
    end else if (!inside_mode && s3 > SW'(r2_3)) begin
      act3 = (max_dist == '0) || (s3 <= SW'(hi2_3));
    end
  end

  logic [SW-1:0] rs   [0:DW];
  logic [RW-1:0] rrem [0:DW];
  logic [DW-1:0] rroot[0:DW];
  logic [W:0]    rdx  [0:DW];
  logic [W:0]    rdy  [0:DW];
  logic [W:0]    rdz  [0:DW];
  logic          ract [0:DW];

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0]    <= s3;
      rrem[0]  <= '0;
      rroot[0] <= '0;
      rdx[0]   <= dx3;
      rdy[0]   <= dy3;
      rdz[0]   <= dz3;
      ract[0]  <= act3 && wr[2] && (s3 != '0);
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar i = 0; i < DW; i++) begin : g_root
    logic [RW-1:0] rem_sh, trial;
    logic          ge;
    assign rem_sh = {rrem[i][RW-3:0], rs[i][SW-1-2*i -: 2]};
    assign trial  = {rroot[i], 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rrem[i+1]  <= ge ? RW'(rem_sh - trial) : rem_sh;
        rroot[i+1] <= {rroot[i][DW-2:0], ge};
        rs[i+1]    <= rs[i];
        rdx[i+1]   <= rdx[i];
        rdy[i+1]   <= rdy[i];
        rdz[i+1]   <= rdz[i];
        ract[i+1]  <= ract[i];
      end
    end
  end

  // gap between radius and distance
  logic [DW-1:0] d_k, kmag_k;
  logic          kneg_k, act_k;
  logic [W:0]    dx_k, dy_k, dz_k;
  logic          kneg_c;
  assign kneg_c = rroot[DW] > DW'(radius);
  always_ff @(posedge clk) begin
    if (en) begin
      d_k    <= rroot[DW];
      kneg_k <= kneg_c;
      kmag_k <= kneg_c ? DW'(rroot[DW] - DW'(radius)) : DW'(DW'(radius) - rroot[DW]);
      act_k  <= ract[DW];
      dx_k   <= rdx[DW];
      dy_k   <= rdy[DW];
      dz_k   <= rdz[DW];
    end
  end

  // dividends: offset magnitude times gap
  logic [W:0]    amx, amy, amz;
  logic [NW-1:0] nx_m, ny_m, nz_m;
  logic [DW-1:0] d_m;
  logic          sx_m, sy_m, sz_m, kill_m;
  assign amx = dx_k[W] ? (W+1)'(-dx_k) : dx_k;
  assign amy = dy_k[W] ? (W+1)'(-dy_k) : dy_k;
  assign amz = dz_k[W] ? (W+1)'(-dz_k) : dz_k;
  always_ff @(posedge clk) begin
    if (en) begin
      nx_m   <= amx * kmag_k;
      ny_m   <= amy * kmag_k;
      nz_m   <= amz * kmag_k;
      d_m    <= d_k;
      sx_m   <= dx_k[W] ^ kneg_k;
      sy_m   <= dy_k[W] ^ kneg_k;
      sz_m   <= dz_k[W] ^ kneg_k;
      kill_m <= !act_k;
    end
  end

  // three divider lanes share one timing
  sbn_div #(.W(W), .DW(DW)) u_div_x (
    .clk(clk), .en(en), .n(nx_m), .d(d_m), .neg(sx_m), .kill(kill_m), .q_out(normal_x)
  );
  sbn_div #(.W(W), .DW(DW)) u_div_y (
    .clk(clk), .en(en), .n(ny_m), .d(d_m), .neg(sy_m), .kill(kill_m), .q_out(normal_y)
  );
  sbn_div #(.W(W), .DW(DW)) u_div_z (
    .clk(clk), .en(en), .n(nz_m), .d(d_m), .neg(sz_m), .kill(kill_m), .q_out(normal_z)
  );

  assign out_valid = vld[LAT-1];
  assign written   = wr[LAT-1];
  assign last_out  = lst[LAT-1];
endmodule
`default_nettype wire

FILE: tb/sbn_checker.sv
// Checker for the sphere boundary normal block: mirrors the register file,
// predicts each result and compares it with the output channel. Uses sbn_pkg.
`default_nettype none
module sbn_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] particle_id,
  input  wire logic [15:0] mk_type,
  input  wire logic        last_particle,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] normal_x,
  input  wire logic [31:0] normal_y,
  input  wire logic [31:0] normal_z,
  input  wire logic        written,
  input  wire logic        last_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        wr;
    logic        last;
  } normal_t;

  normal_t normals_due[$];

  // register mirror
  logic [31:0] cx, cy, cz, bnd_count, mk_rng;
  logic [30:0] rad, maxd;
  logic        in_mode;

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0]  r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= s) r = c[63:0];
    end
    return r;
  endfunction

  // one axis: dv * k / d truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] axis_normal(logic signed [63:0] dv, logic [63:0] kmag,
                                              logic kneg, logic [63:0] d);
    logic [127:0] q;
    logic [63:0]  mag;
    logic         neg;
    neg = (dv < 0) != kneg;
    mag = (dv < 0) ? -dv : dv;
    // a zero root makes the quotient saturate
    if (d == 0) q = '1;
    else q = ({64'd0, mag} * {64'd0, kmag}) / {64'd0, d};
    if (q == 0) return 32'd0;
    if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    if (q > 128'h80000000) q = 128'h80000000;
    return 32'(-q[31:0]);
  endfunction

  function automatic normal_t predict_normal(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] id,
                                             logic [15:0] mk, logic lst);
    normal_t            n;
    logic signed [63:0] dx, dy, dz;
    logic [63:0]        mx, my, mz;
    logic [127:0]       s, r2, lim;
    logic [63:0]        d, kmag;
    logic               act, kneg;
    n = '0;
    n.last = lst;
    n.wr = (id < bnd_count) && (mk >= mk_rng[15:0]) && (mk <= mk_rng[31:16]);
    if (n.wr) begin
      dx = 64'(signed'(px)) - 64'(signed'(cx));
      dy = 64'(signed'(py)) - 64'(signed'(cy));
      dz = 64'(signed'(pz)) - 64'(signed'(cz));
      mx = (dx < 0) ? 64'(-dx) : 64'(dx);
      my = (dy < 0) ? 64'(-dy) : 64'(dy);
      mz = (dz < 0) ? 64'(-dz) : 64'(dz);
      s = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
          + {64'd0, mz} * {64'd0, mz};
      r2 = 128'(rad) * 128'(rad);
      act = 1'b0;
      if (in_mode && s < r2) begin
        lim = 128'(rad - maxd) * 128'(rad - maxd);
        act = (maxd == 0) || (rad <= maxd) || (s >= lim);
      end else if (!in_mode && s > r2) begin
        lim = (128'(rad) + 128'(maxd)) * (128'(rad) + 128'(maxd));
        act = (maxd == 0) || (s <= lim);
      end
      if (act && s != 0) begin
        d = isqrt(s);
        kneg = d > rad;
        kmag = kneg ? d - rad : 64'(rad) - d;
        n.nx = axis_normal(dx, kmag, kneg, d);
        n.ny = axis_normal(dy, kmag, kneg, d);
        n.nz = axis_normal(dz, kmag, kneg, d);
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin
    normal_t got, want;
    if (rst) begin
      cx <= '0; cy <= '0; cz <= '0; rad <= '0; in_mode <= 1'b0; maxd <= '0;
      bnd_count <= '0; mk_rng <= sbn_pkg::MK_RANGE_RST;
      fail_count <= 0;
      checked <= 0;
      normals_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (sbn_pkg::reg_idx_t'(cfg_index))
          sbn_pkg::REG_CENTER_X:  cx <= cfg_data;
          sbn_pkg::REG_CENTER_Y:  cy <= cfg_data;
          sbn_pkg::REG_CENTER_Z:  cz <= cfg_data;
          sbn_pkg::REG_RADIUS:    rad <= cfg_data[30:0];
          sbn_pkg::REG_INSIDE:    in_mode <= cfg_data[0];
          sbn_pkg::REG_MAX_DIST:  maxd <= cfg_data[30:0];
          sbn_pkg::REG_BND_COUNT: bnd_count <= cfg_data;
          sbn_pkg::REG_MK_RANGE:  mk_rng <= cfg_data;
          default: ;
        endcase
      end
      // accepted particle
      if (in_valid && in_ready)
        normals_due = {normals_due, predict_normal(pos_x, pos_y, pos_z, particle_id,
                                                   mk_type, last_particle)};
      // accepted result
      if (out_valid && out_ready) begin
        got = '{normal_x, normal_y, normal_z, written, last_out};
        checked <= checked + 1;
        if (normals_due.size() == 0) begin
          $error("result with no particle outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = normals_due.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.nx != want.nx)
            $error("normal_x expected %h actual %h", want.nx, got.nx);
          if (got.ny != want.ny)
            $error("normal_y expected %h actual %h", want.ny, got.ny);
          if (got.nz != want.nz)
            $error("normal_z expected %h actual %h", want.nz, got.nz);
          if (got.wr != want.wr)
            $error("written expected %0d actual %0d", want.wr, got.wr);
          if (got.last != want.last)
            $error("last_out expected %0d actual %0d", want.last, got.last);
        end
      end
    end
    pending <= normals_due.size();
  end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Top of the sphere boundary normal testbench: clock, reset, register set-up
// and particle stimulus. Needs sbn_pkg, sphere_boundary_normal and sbn_checker.
`default_nettype none
module tb;
  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [31:0] pos_x, pos_y, pos_z, particle_id;
  logic [15:0] mk_type;
  logic        last_particle;
  logic [31:0] normal_x, normal_y, normal_z;
  logic        written, last_out;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, checked;
  logic        calm;       // no idling on either side while set

  // current set-up, used to aim particles at the sphere
  logic [31:0] cur_c [3];
  logic [30:0] cur_rad;
  logic [31:0] cur_bnd, cur_mk;

  sphere_boundary_normal u_dut (.*);

  sbn_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 4_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // result side: stall a random number of cycles before each transaction
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(sbn_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      sbn_pkg::REG_CENTER_X:  cur_c[0] = val;
      sbn_pkg::REG_CENTER_Y:  cur_c[1] = val;
      sbn_pkg::REG_CENTER_Z:  cur_c[2] = val;
      sbn_pkg::REG_RADIUS:    cur_rad = val[30:0];
      sbn_pkg::REG_BND_COUNT: cur_bnd = val;
      sbn_pkg::REG_MK_RANGE:  cur_mk = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [30:0] r, logic ins, logic [30:0] md,
                            logic [31:0] bnd, logic [31:0] mkr);
    wait_drained();
    write_reg(sbn_pkg::REG_CENTER_X, x);
    write_reg(sbn_pkg::REG_CENTER_Y, y);
    write_reg(sbn_pkg::REG_CENTER_Z, z);
    write_reg(sbn_pkg::REG_RADIUS, {1'b0, r});
    write_reg(sbn_pkg::REG_INSIDE, {31'd0, ins});
    write_reg(sbn_pkg::REG_MAX_DIST, {1'b0, md});
    write_reg(sbn_pkg::REG_BND_COUNT, bnd);
    write_reg(sbn_pkg::REG_MK_RANGE, mkr);
  endtask

  // drive one transaction; valid drops once it is taken unless the next follows
  task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] id, logic [15:0] mk, logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pos_x = x; pos_y = y; pos_z = z;
    particle_id = id; mk_type = mk; last_particle = lst;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random particle, mostly placed near the sphere surface and selected
  task automatic send_random();
    logic [31:0] p [3];
    logic [31:0] id;
    logic [15:0] mk;
    int          span, pick;
    pick = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      if (pick < 15) p[a] = $urandom;
      else begin
        span = $urandom_range(0, 31);
        p[a] = cur_c[a] + 32'($signed(32'($urandom) >>> span))
               + ($urandom_range(0, 1) ? {1'b0, cur_rad} >> $urandom_range(0, 3) : 32'd0);
      end
    end
    if ($urandom_range(0, 9) < 8 && cur_bnd != 0) id = $urandom_range(0, cur_bnd - 1);
    else id = $urandom;
    if ($urandom_range(0, 9) < 8 && cur_mk[15:0] <= cur_mk[31:16])
      mk = 16'($urandom_range(cur_mk[15:0], cur_mk[31:16]));
    else mk = 16'($urandom);
    send_particle(p[0], p[1], p[2], id, mk, 1'($urandom_range(0, 1)));
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    int phase_items;
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    particle_id = '0; mk_type = '0; last_particle = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0;
    cur_c = '{default: '0}; cur_rad = '0; cur_bnd = '0; cur_mk = sbn_pkg::MK_RANGE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset set-up: nothing is selected
    send_particle(ONE, 0, 0, 0, 0, 1'b1);

    // directed, outside mode, radius 4, unlimited distance, mk 3..9, ids below 100
    set_sphere(0, 0, 0, 31'(4 * ONE), 1'b0, 0, 100, {16'd9, 16'd3});
    send_particle(0, 0, 0, 1, 5, 1'b0);                        // centre hit
    send_particle(4 * ONE, 0, 0, 1, 5, 1'b0);                  // on the surface
    send_particle(10 * ONE, -(3 * ONE), 7 * ONE, 2, 3, 1'b0);  // outside, first mk
    send_particle(ONE, ONE, 0, 2, 9, 1'b0);                    // wrong side, last mk
    send_particle(10 * ONE, 0, 0, 100, 5, 1'b0);               // id at the count
    send_particle(10 * ONE, 0, 0, 1, 10, 1'b0);                // mk above the range
    send_particle(10 * ONE, 0, 0, 1, 2, 1'b0);                 // mk below the range
    send_particle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 4, 1'b1);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 99, 6, 1'b0);

    // directed, inside mode with a distance limit, extreme centre
    set_sphere(32'h80000000, 32'h7FFFFFFF, 0, 31'h7FFFFFFF, 1'b1, 31'(2 * ONE),
               32'hFFFFFFFF, 32'hFFFF0000);
    send_particle(32'h80000000, 32'h7FFFFFFF, 0, 32'hFFFFFFFE, 16'hFFFF, 1'b0);
    send_particle(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1'b0);
    send_particle(32'h80000000, 32'h7FFFFFFF, 32'h7FFF0000, 5, 7, 1'b1);
    send_particle(32'h7FFFFFFF, 32'h80000000, 0, 5, 7, 1'b0);
    // saturation: huge radius, outside point, unlimited
    set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 1'b0, 0,
               32'hFFFFFFFF, 32'hFFFF0000);
    send_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1'b0);
    send_particle(32'h80000000, 32'h80000000, 32'h80000001, 1, 1, 1'b1);
    // empty mk interval
    set_sphere(0, 0, 0, 31'(ONE), 1'b0, 31'h7FFFFFFF, 10, {16'd3, 16'd9});
    send_particle(5 * ONE, 0, 0, 1, 5, 1'b0);
    send_particle(ONE * 2, 0, 0, 1, 9, 1'b0);

    // random phases, each under a fresh sphere set-up
    for (int ph = 0; ph < 10; ph++) begin
      logic [30:0] r, md;
      logic [31:0] bnd, mkr, c0, c1, c2;
      case ($urandom_range(0, 3))
        0: r = 31'h7FFFFFFF;
        1: r = 0;
        default: r = 31'($urandom_range(1, 32'h00FFFFFF) << $urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 3))
        0: md = 0;
        1: md = 31'h7FFFFFFF;
        default: md = r >> $urandom_range(0, 4);
      endcase
      case ($urandom_range(0, 3))
        0: bnd = 32'hFFFFFFFF;
        1: bnd = 0;
        default: bnd = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: mkr = 32'hFFFF0000;
        1: mkr = $urandom;
        default: mkr = {16'($urandom_range(16'h8000, 16'hFFFF)),
                        16'($urandom_range(0, 16'h7FFF))};
      endcase
      c0 = $urandom; c1 = $urandom; c2 = $urandom;
      if ($urandom_range(0, 1)) begin
        c0 = $signed(c0) >>> 8; c1 = $signed(c1) >>> 8; c2 = $signed(c2) >>> 8;
      end
      set_sphere(c0, c1, c2, r, 1'($urandom_range(0, 1)), md, bnd, mkr);
      phase_items = 165;
      for (int i = 0; i < phase_items; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_random();
      end
      calm = 1'b0;
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("Run covered %0d particle results over directed and ten random sphere set-ups,",
             checked);
    $display("with random idling on both channels and drained pauses between set-ups.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
